>>> rtl/slsd_pkg.sv
package slsd_pkg;

	localparam int RING_DEPTH_DEF = 256;
	localparam int MIN_FRAME_DEF  = 4;
	localparam int MAX_FRAME_DEF  = 64;

	localparam logic [7:0] SYNC_FIRST  = 8'hEB;
	localparam logic [7:0] SYNC_SECOND = 8'h90;
	localparam logic [7:0] SUM_GOOD    = 8'h00;

	localparam logic [2:0] ST_STORED  = 3'd0;
	localparam logic [2:0] ST_WAIT    = 3'd1;
	localparam logic [2:0] ST_DROP    = 3'd2;
	localparam logic [2:0] ST_FRAME   = 3'd3;
	localparam logic [2:0] ST_BAD     = 3'd4;
	localparam logic [2:0] ST_OVERRUN = 3'd5;

endpackage

>>> rtl/sync_length_sum_deframer.sv
// timing: a push result is registered once the request is taken and the output is free; a poll
// reads the sync pair and the length, and a frame is first summed over all len bytes, also when
// the checksum turns out bad, before a good frame gives out its bytes in order
// throughput: one request at a time, as one read port walks the frame for the sum and then
// again for the bytes; each result waits while the output is held by back-pressure
// reset: read and write points cleared; the ring memory is not cleared, only held entries are read
module sync_length_sum_deframer #(
	parameter int RING_DEPTH = slsd_pkg::RING_DEPTH_DEF,
	parameter int MIN_FRAME  = slsd_pkg::MIN_FRAME_DEF,
	parameter int MAX_FRAME  = slsd_pkg::MAX_FRAME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // rx_byte
	input  logic [0:0] s_tuser,  // mode
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // frame_byte
	output logic [2:0] m_tuser,  // status
	output logic       m_tlast   // last
);

	localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int KW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
	localparam int SW = 9;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PUSH   = 4'd1;
	localparam logic [3:0] S_POLL   = 4'd2;
	localparam logic [3:0] S_HDR0   = 4'd3;
	localparam logic [3:0] S_HDR1   = 4'd4;
	localparam logic [3:0] S_LEN    = 4'd5;
	localparam logic [3:0] S_SUM    = 4'd6;
	localparam logic [3:0] S_SUMEND = 4'd7;
	localparam logic [3:0] S_CHK    = 4'd8;
	localparam logic [3:0] S_EMA    = 4'd9;
	localparam logic [3:0] S_EMD    = 4'd10;
	localparam logic [3:0] S_REPORT = 4'd11;

	logic [7:0]    ring_q [RING_DEPTH];
	logic [7:0]    rd_data_q;
	logic [PW-1:0] rd_addr;
	logic [SW-1:0] rd_off;

	logic [3:0]    state_q;
	logic [PW-1:0] wp_q, rp_q;
	logic [7:0]    byte_q;
	logic          sync_q;
	logic [7:0]    len_q;
	logic [KW-1:0] k_q;
	logic [7:0]    sum_q;
	logic          sum_v_s1;
	logic [2:0]    rep_status_q;

	logic          m_tvalid_q, m_tlast_q;
	logic [7:0]    m_tdata_q;
	logic [2:0]    m_tuser_q;

	logic [PW:0]   held;
	logic          out_free;
	logic          out_load;
	logic          k_last;

	// base plus offset, wrapped once around the ring
	function automatic logic [PW-1:0] ring_pos(input logic [PW-1:0] base,
		input logic [SW-1:0] off);
		logic [SW:0] s;
		s = (SW+1)'(base) + (SW+1)'(off);
		if (s >= (SW+1)'(RING_DEPTH))
			s = s - (SW+1)'(RING_DEPTH);
		return s[PW-1:0];
	endfunction

	assign held = (wp_q >= rp_q) ? ((PW+1)'(wp_q) - (PW+1)'(rp_q))
		: ((PW+1)'(wp_q) + (PW+1)'(RING_DEPTH) - (PW+1)'(rp_q));
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = out_free
		&& (state_q == S_PUSH || state_q == S_EMD || state_q == S_REPORT);
	assign k_last   = (8'(k_q) + 8'd1) == len_q;
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		unique case (state_q)
			S_HDR0:                    rd_off = SW'(1);
			S_HDR1:                    rd_off = SW'(2);
			S_SUM, S_EMA, S_EMD:       rd_off = SW'(k_q);
			default:                   rd_off = '0;
		endcase
	end
	assign rd_addr = ring_pos(rp_q, rd_off);

	always_ff @(posedge clk) begin
		rd_data_q <= ring_q[rd_addr];
		if (state_q == S_PUSH && out_free && held < (PW+1)'(RING_DEPTH - 1))
			ring_q[wp_q] <= byte_q;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_q <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wp_q         <= '0;
			rp_q         <= '0;
			sync_q       <= 1'b0;
			len_q        <= '0;
			k_q          <= '0;
			sum_q        <= '0;
			sum_v_s1     <= 1'b0;
			rep_status_q <= slsd_pkg::ST_WAIT;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
			m_tlast_q    <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && !out_load)
				m_tvalid_q <= 1'b0;

			// read data is registered, so the sum adds it in the cycle after its address
			sum_v_s1 <= (state_q == S_SUM);
			if (sum_v_s1)
				sum_q <= sum_q + rd_data_q;

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid)
						state_q <= s_tuser[0] ? S_POLL : S_PUSH;
				end
				S_PUSH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= '0;
						m_tlast_q  <= 1'b0;
						if (held >= (PW+1)'(RING_DEPTH - 1)) begin
							m_tuser_q <= slsd_pkg::ST_OVERRUN;
						end else begin
							m_tuser_q <= slsd_pkg::ST_STORED;
							wp_q      <= ring_pos(wp_q, SW'(1));
						end
						state_q <= S_IDLE;
					end
				end
				S_POLL: begin
					if (held < (PW+1)'(MIN_FRAME)) begin
						rep_status_q <= slsd_pkg::ST_WAIT;
						state_q      <= S_REPORT;
					end else begin
						state_q <= S_HDR0;
					end
				end
				S_HDR0: begin
					sync_q  <= (rd_data_q == slsd_pkg::SYNC_FIRST);
					state_q <= S_HDR1;
				end
				S_HDR1: begin
					sync_q  <= sync_q && (rd_data_q == slsd_pkg::SYNC_SECOND);
					state_q <= S_LEN;
				end
				S_LEN: begin
					len_q   <= rd_data_q;
					k_q     <= '0;
					sum_q   <= '0;
					state_q <= S_REPORT;
					priority if (!sync_q) begin
						rp_q         <= ring_pos(rp_q, SW'(1));
						rep_status_q <= slsd_pkg::ST_DROP;
					end else if (rd_data_q < 8'(MIN_FRAME) || rd_data_q > 8'(MAX_FRAME)
						|| SW'(rd_data_q) > SW'(RING_DEPTH - 1)) begin
						rp_q         <= ring_pos(rp_q, SW'(2));
						rep_status_q <= slsd_pkg::ST_BAD;
					end else if (SW'(held) < SW'(rd_data_q)) begin
						rep_status_q <= slsd_pkg::ST_WAIT;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (k_last) begin
						state_q <= S_SUMEND;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				S_SUMEND: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					k_q <= '0;
					if (sum_q != slsd_pkg::SUM_GOOD) begin
						rp_q         <= ring_pos(rp_q, SW'(2));
						rep_status_q <= slsd_pkg::ST_BAD;
						state_q      <= S_REPORT;
					end else begin
						state_q <= S_EMA;
					end
				end
				S_EMA: begin
					state_q <= S_EMD;
				end
				S_EMD: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= rd_data_q;
						m_tuser_q  <= slsd_pkg::ST_FRAME;
						m_tlast_q  <= k_last;
						if (k_last) begin
							rp_q    <= ring_pos(rp_q, SW'(len_q));
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= S_EMA;
						end
					end
				end
				S_REPORT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= '0;
						m_tuser_q  <= rep_status_q;
						m_tlast_q  <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

>>> verif/tb_sync_length_sum_deframer.sv
`timescale 1ns / 100ps

module tb_sync_length_sum_deframer;

	localparam int RING = slsd_pkg::RING_DEPTH_DEF;
	localparam int MINF = slsd_pkg::MIN_FRAME_DEF;
	localparam int MAXF = slsd_pkg::MAX_FRAME_DEF;
	localparam int CALM_FROM = 120;
	localparam int CALM_TO = 200;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] fbyte;
		logic       last;
	} frame_result_t;

	class deframe_scoreboard;
		bit [7:0] ring [RING];
		int unsigned wr_pt;
		int unsigned rd_pt;
		frame_result_t pending_results[$];
		int errors;

		function new();
			wr_pt = 0;
			rd_pt = 0;
			errors = 0;
		endfunction

		function int unsigned held();
			return (wr_pt + RING - rd_pt) % RING;
		endfunction

		function void expect_single(logic [2:0] st);
			frame_result_t r;
			r.status = st;
			r.fbyte = 8'h00;
			r.last = 1'b0;
			pending_results.push_back(r);
		endfunction

		// works out what one accepted request will produce; returns the first status
		function logic [2:0] note_request(bit poll, bit [7:0] d);
			int unsigned h;
			int unsigned len;
			int unsigned sum;
			int unsigned k;
			frame_result_t r;
			if (!poll) begin
				// one slot always stays free
				if (held() >= RING - 1) begin
					expect_single(slsd_pkg::ST_OVERRUN);
					return slsd_pkg::ST_OVERRUN;
				end
				ring[wr_pt] = d;
				wr_pt = (wr_pt + 1) % RING;
				expect_single(slsd_pkg::ST_STORED);
				return slsd_pkg::ST_STORED;
			end
			h = held();
			if (h < MINF) begin
				expect_single(slsd_pkg::ST_WAIT);
				return slsd_pkg::ST_WAIT;
			end
			if (ring[rd_pt] != slsd_pkg::SYNC_FIRST
				|| ring[(rd_pt + 1) % RING] != slsd_pkg::SYNC_SECOND) begin
				rd_pt = (rd_pt + 1) % RING;
				expect_single(slsd_pkg::ST_DROP);
				return slsd_pkg::ST_DROP;
			end
			len = 32'(ring[(rd_pt + 2) % RING]);
			if (len < MINF || len > MAXF || len > RING - 1) begin
				rd_pt = (rd_pt + 2) % RING;
				expect_single(slsd_pkg::ST_BAD);
				return slsd_pkg::ST_BAD;
			end
			if (h < len) begin
				expect_single(slsd_pkg::ST_WAIT);
				return slsd_pkg::ST_WAIT;
			end
			sum = 0;
			for (k = 0; k < len; k++)
				sum = (sum + 32'(ring[(rd_pt + k) % RING])) & 32'hFF;
			if (sum != 32'(slsd_pkg::SUM_GOOD)) begin
				// only the sync pair is skipped on a bad checksum
				rd_pt = (rd_pt + 2) % RING;
				expect_single(slsd_pkg::ST_BAD);
				return slsd_pkg::ST_BAD;
			end
			for (k = 0; k < len; k++) begin
				r.status = slsd_pkg::ST_FRAME;
				r.fbyte = ring[(rd_pt + k) % RING];
				r.last = (k + 1 == len);
				pending_results.push_back(r);
			end
			rd_pt = (rd_pt + len) % RING;
			return slsd_pkg::ST_FRAME;
		endfunction

		function void check_result(logic [2:0] st, logic [7:0] fb, logic lt);
			frame_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: status %0d byte %02h last %0b", st, fb, lt);
				return;
			end
			want = pending_results.pop_front();
			if (st !== want.status || fb !== want.fbyte || lt !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected status %0d byte %02h last %0b, got %0d %02h %0b",
						want.status, want.fbyte, want.last, st, fb, lt);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic [0:0] s_tuser = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	deframe_scoreboard sb;
	bit calm = 1'b0;
	int unsigned sent_count = 0;

	sync_length_sum_deframer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #5 clk = ~clk;

	// result side: random back-pressure, check on every accepted result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata, m_tlast);
		m_tready <= calm || ($urandom_range(0, 99) >= 36);
	end

	// sync pair, length, payload, then a byte that brings the sum to zero
	function automatic void make_frame(input int unsigned len, input bit corrupt,
			output bit [7:0] q[$]);
		bit [7:0] s;
		bit [7:0] ck;
		int unsigned i;
		int unsigned pos;
		q = {};
		q.push_back(slsd_pkg::SYNC_FIRST);
		q.push_back(slsd_pkg::SYNC_SECOND);
		q.push_back(len[7:0]);
		for (i = 3; i + 1 < len; i++)
			q.push_back(8'($urandom_range(0, 255)));
		s = 8'h00;
		foreach (q[j])
			s = s + q[j];
		ck = 8'd0 - s;
		q.push_back(ck);
		if (corrupt) begin
			pos = $urandom_range(3, len - 1);
			q[pos] = q[pos] + 8'($urandom_range(1, 255));
		end
	endfunction

	task automatic send_request(input bit poll, input bit [7:0] d, output logic [2:0] st);
		while (!calm && $urandom_range(0, 99) < 36) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= poll;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		st = sb.note_request(poll, d);
		sent_count++;
	endtask

	task automatic push_bytes(input bit [7:0] q[$], input int unsigned poll_pct);
		logic [2:0] st;
		foreach (q[i]) begin
			send_request(1'b0, q[i], st);
			if ($urandom_range(0, 99) < poll_pct)
				send_request(1'b1, 8'($urandom_range(0, 255)), st);
		end
	endtask

	task automatic poll_times(input int unsigned n);
		logic [2:0] st;
		repeat (n)
			send_request(1'b1, 8'($urandom_range(0, 255)), st);
	endtask

	task automatic drain_ring();
		logic [2:0] st;
		st = slsd_pkg::ST_DROP;
		while (st != slsd_pkg::ST_WAIT)
			send_request(1'b1, 8'($urandom_range(0, 255)), st);
	endtask

	// one random piece of line traffic: a frame, a bad length header or noise
	task automatic push_random_chunk(input int unsigned poll_pct);
		bit [7:0] fq[$];
		int unsigned len;
		int unsigned choice;
		choice = $urandom_range(0, 99);
		if (choice < 70) begin
			if (choice < 5)
				len = MAXF;
			else if ($urandom_range(0, 4) == 0)
				len = $urandom_range(MINF, MAXF);
			else
				len = $urandom_range(MINF, 12);
			// mostly good frames, some with a broken checksum
			make_frame(len, choice >= 62, fq);
		end else if (choice < 85) begin
			fq = {slsd_pkg::SYNC_FIRST, slsd_pkg::SYNC_SECOND};
			if ($urandom_range(0, 1))
				fq.push_back(8'($urandom_range(0, MINF - 1)));
			else
				fq.push_back(8'($urandom_range(MAXF + 1, 255)));
			repeat ($urandom_range(0, 3))
				fq.push_back(8'($urandom_range(0, 255)));
		end else begin
			fq = {};
			repeat ($urandom_range(1, 5))
				fq.push_back(8'($urandom_range(0, 255)));
		end
		push_bytes(fq, poll_pct);
	endtask

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		bit [7:0] fq[$];
		bit [7:0] rest[$];
		logic [2:0] st;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// poll on an empty ring
		poll_times(1);
		// shortest good frame
		make_frame(MINF, 1'b0, fq);
		push_bytes(fq, 0);
		poll_times(1);
		// extreme noise bytes, then a length above the largest frame
		fq = {8'h00, 8'hFF, slsd_pkg::SYNC_FIRST, slsd_pkg::SYNC_SECOND, 8'(MAXF + 1), 8'h07};
		push_bytes(fq, 0);
		poll_times(4);
		// checksum failure
		make_frame(MINF, 1'b1, fq);
		push_bytes(fq, 0);
		poll_times(3);
		// frame held only in part, completed afterwards
		make_frame(16, 1'b0, fq);
		push_bytes(fq[0:3], 0);
		poll_times(3);
		rest = fq[4:$];
		push_bytes(rest, 0);
		poll_times(1);

		// random frames and noise until the ring is full, wrapping both points
		while (sb.held() < RING - 1) begin
			calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);
			push_random_chunk(0);
		end
		calm = 1'b0;
		repeat (2)
			send_request(1'b0, 8'($urandom_range(0, 255)), st);
		drain_ring();
		s_tvalid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		sb.errors += sb.pending_results.size();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
